[hw/rtl/psc_pkg.sv]
`timescale 1ns / 1ps

package psc_pkg;

	localparam int TRACK_BITS_DEF = 16;
	localparam int SEQ_BITS_DEF   = 32;

	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 96;
	localparam int CFG_W      = 16;
	localparam int SKIP_CNT_W = 16;
	localparam int ERR_W      = 4;

	typedef enum logic [1:0] {
		OP_INIT = 2'd0,
		OP_PLAY = 2'd1,
		OP_STOP = 2'd2,
		OP_TICK = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE      = 3'd0,
		ST_STOPPED   = 3'd1,
		ST_PLAYING   = 3'd2,
		ST_ADVANCING = 3'd3,
		ST_ENDED     = 3'd4,
		ST_ERROR     = 3'd5
	} play_state_t;

	localparam logic [ERR_W-1:0] ERR_NONE  = 4'd0;
	localparam logic [ERR_W-1:0] ERR_RESET = 4'd1;

endpackage

[hw/rtl/playback_sequence_controller_unit.sv]
// Path: a command word accepted on s_axis passes the input register, then the state/result
// register, before its snapshot shows on m_axis.
// Throughput: one command word per cycle unless m_axis stalls; the single-pass update
// between the input and state registers sets this; input is taken while a result waits.
// Reset: arst_n asynchronously clears all player state, the track count and both valids.
`timescale 1ns / 1ps

module playback_sequence_controller_unit
	import psc_pkg::*;
#(
	parameter int TRACK_BITS = TRACK_BITS_DEF,
	parameter int SEQ_BITS   = SEQ_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_W-1:0]      cfg_wr_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// track_number[15:0], stop_ok[16], second_stop_ok[17], open_error[21:18],
	// engine_error[25:22], engine_ended[26], zero fill above.
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// opcode[1:0]
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// play_state[2:0], error_code[6:3], publish_count[38:7], current_track[54:39],
	// skip_trk[70:55], skip_code[74:71], skip_total[90:75], init_ok[91],
	// zero fill above.
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int CMP_W = (TRACK_BITS > CFG_W) ? TRACK_BITS : CFG_W;

	logic                  valid_s1;
	opcode_t               opcode_s1;
	logic [TRACK_BITS-1:0] track_s1;
	logic                  stop_ok_s1;
	logic                  stop2_ok_s1;
	logic [ERR_W-1:0]      open_err_s1;
	logic [ERR_W-1:0]      eng_err_s1;
	logic                  ended_s1;

	logic [CFG_W-1:0]      track_count_q;
	logic                  init_q;
	play_state_t           state_q;
	logic [ERR_W-1:0]      err_q;
	logic [SEQ_BITS-1:0]   seq_q;
	logic [TRACK_BITS-1:0] track_q;
	logic [TRACK_BITS-1:0] skip_track_q;
	logic [ERR_W-1:0]      skip_err_q;
	logic [SKIP_CNT_W-1:0] skip_cnt_q;
	logic                  init_ok_q;
	logic                  out_valid_q;

	logic                  advance;

	logic                  init_n;
	play_state_t           state_n;
	logic [ERR_W-1:0]      err_n;
	logic [SEQ_BITS-1:0]   seq_n;
	logic [TRACK_BITS-1:0] track_n;
	logic [TRACK_BITS-1:0] skip_track_n;
	logic [ERR_W-1:0]      skip_err_n;
	logic [SKIP_CNT_W-1:0] skip_cnt_n;
	logic                  init_ok_n;

	logic                  do_post;
	play_state_t           post_state;
	logic [ERR_W-1:0]      post_err;
	logic                  usable;
	logic [TRACK_BITS-1:0] next_track;
	logic                  conc_en;
	logic [ERR_W-1:0]      conc_err_in;
	logic                  conc_stop;
	logic [TRACK_BITS-1:0] conc_track;
	logic [SKIP_CNT_W-1:0] conc_cnt_base;
	logic [ERR_W-1:0]      conc_err;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, init_ok_q, skip_cnt_q, skip_err_q, CFG_W'(skip_track_q),
		CFG_W'(track_q), 32'(seq_q), err_q, state_q};

	assign next_track = track_q + TRACK_BITS'(1);

	always_comb begin
		init_n        = init_q;
		track_n       = track_q;
		skip_track_n  = skip_track_q;
		skip_err_n    = skip_err_q;
		skip_cnt_n    = skip_cnt_q;
		init_ok_n     = 1'b0;
		do_post       = 1'b0;
		post_state    = state_q;
		post_err      = err_q;
		usable        = 1'b0;
		conc_en       = 1'b0;
		conc_err_in   = ERR_NONE;
		conc_stop     = 1'b1;
		conc_track    = track_q;
		conc_cnt_base = skip_cnt_q;
		conc_err      = ERR_NONE;

		case (opcode_s1)
			OP_INIT: begin
				if (!init_q) begin
					init_n  = 1'b1;
					do_post = 1'b1;
					if (stop_ok_s1) begin
						post_state = ST_STOPPED;
						post_err   = ERR_NONE;
						init_ok_n  = 1'b1;
					end else begin
						post_state = ST_ERROR;
						post_err   = ERR_RESET;
					end
				end
			end
			OP_PLAY, OP_STOP: begin
				usable = init_q && (err_q != ERR_RESET) && ((opcode_s1 == OP_STOP) ||
					((track_s1 != '0) && (CMP_W'(track_s1) <= CMP_W'(track_count_q))));
				if (usable) begin
					if (!stop_ok_s1) begin
						do_post    = 1'b1;
						post_state = ST_ERROR;
						post_err   = ERR_RESET;
					end else if (opcode_s1 == OP_STOP) begin
						do_post    = 1'b1;
						post_state = ST_STOPPED;
						post_err   = ERR_NONE;
					end else begin
						skip_track_n = '0;
						skip_err_n   = ERR_NONE;
						skip_cnt_n   = '0;
						track_n      = track_s1;
						if (open_err_s1 != ERR_NONE) begin
							conc_en       = 1'b1;
							conc_err_in   = open_err_s1;
							conc_stop     = stop2_ok_s1;
							conc_track    = track_s1;
							conc_cnt_base = '0;
						end else begin
							do_post    = 1'b1;
							post_state = ST_PLAYING;
							post_err   = ERR_NONE;
						end
					end
				end
			end
			OP_TICK: begin
				if (state_q == ST_ADVANCING) begin
					track_n = next_track;
					if (open_err_s1 != ERR_NONE) begin
						conc_en     = 1'b1;
						conc_err_in = open_err_s1;
						conc_stop   = stop_ok_s1;
						conc_track  = next_track;
					end else begin
						do_post    = 1'b1;
						post_state = ST_PLAYING;
						post_err   = ERR_NONE;
					end
				end else if (state_q == ST_PLAYING) begin
					if ((eng_err_s1 != ERR_NONE) || ended_s1) begin
						conc_en     = 1'b1;
						conc_err_in = eng_err_s1;
						conc_stop   = stop_ok_s1;
					end
				end
			end
			default: begin
				do_post = 1'b0;
			end
		endcase

		if (conc_en) begin
			conc_err = conc_stop ? conc_err_in : ERR_RESET;
			do_post  = 1'b1;
			post_err = conc_err;
			if (conc_err == ERR_RESET) begin
				post_state = ST_ERROR;
			end else begin
				if (conc_err != ERR_NONE) begin
					skip_track_n = conc_track;
					skip_err_n   = conc_err;
					skip_cnt_n   = conc_cnt_base + SKIP_CNT_W'(1);
				end
				if (CMP_W'(conc_track) < CMP_W'(track_count_q)) begin
					post_state = ST_ADVANCING;
				end else if (conc_err == ERR_NONE) begin
					post_state = ST_ENDED;
				end else begin
					post_state = ST_ERROR;
				end
			end
		end

		state_n = do_post ? post_state : state_q;
		err_n   = do_post ? post_err : err_q;
		seq_n   = do_post ? (seq_q + SEQ_BITS'(1)) : seq_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			opcode_s1   <= opcode_t'(s_axis_tuser);
			track_s1    <= TRACK_BITS'(s_axis_tdata[15:0]);
			stop_ok_s1  <= s_axis_tdata[16];
			stop2_ok_s1 <= s_axis_tdata[17];
			open_err_s1 <= s_axis_tdata[21:18];
			eng_err_s1  <= s_axis_tdata[25:22];
			ended_s1    <= s_axis_tdata[26];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_count_q <= '0;
		end else if (cfg_wr_en) begin
			track_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q       <= 1'b0;
			state_q      <= ST_IDLE;
			err_q        <= ERR_NONE;
			seq_q        <= '0;
			track_q      <= '0;
			skip_track_q <= '0;
			skip_err_q   <= ERR_NONE;
			skip_cnt_q   <= '0;
			init_ok_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				init_q       <= init_n;
				state_q      <= state_n;
				err_q        <= err_n;
				seq_q        <= seq_n;
				track_q      <= track_n;
				skip_track_q <= skip_track_n;
				skip_err_q   <= skip_err_n;
				skip_cnt_q   <= skip_cnt_n;
				init_ok_q    <= init_ok_n;
				out_valid_q  <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/psc_checker.sv]
`timescale 1ns / 1ps

module psc_checker
	import psc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	// The input side only backs up when the output side is stalled.
	a_ready_unless_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!(m_axis_tvalid && !m_axis_tready) |-> s_axis_tready)
		else $error("input not ready while output is free");

	// Every accepted command is followed by a valid result word.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |-> ##2 m_axis_tvalid)
		else $error("no result word after an accepted command");

	// A stalled result word holds its contents.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result word changed");

	// A successful initialize always leaves the player stopped with no error.
	a_init_ok_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[91]) |->
			((m_axis_tdata[2:0] == ST_STOPPED) && (m_axis_tdata[6:3] == ERR_NONE)))
		else $error("init_ok without stopped state");

	// The reset error code is only ever published together with the error state.
	a_reset_err_state: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[6:3] == ERR_RESET)) |->
			(m_axis_tdata[2:0] == ST_ERROR))
		else $error("reset error outside the error state");

endmodule

bind playback_sequence_controller_unit psc_checker u_psc_checker (.*);
